// ----- sv/lprp_pkg.sv -----
// Shared constants and helpers for the length-prefixed request parser.
// Used by the channel interfaces and the parser top level; depends on nothing.

package lprp_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 32;
   localparam int ARG_IDX_W   = 24;
   localparam int ROLE_W      = 3;
   localparam int CMD_W       = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_FRAME_LEN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MAX_ARGS      = 2'd1;

   localparam logic [WORD_W-1:0]    MAX_FRAME_LEN_RESET = 32'd33554432;
   localparam logic [ARG_IDX_W-1:0] MAX_ARGS_RESET      = 24'd200000;

   // Parser phases; these double as the role codes of the bytes they tag.
   localparam logic [2:0] PH_LEN     = 3'd0;
   localparam logic [2:0] PH_COUNT   = 3'd1;
   localparam logic [2:0] PH_ARGLEN  = 3'd2;
   localparam logic [2:0] PH_CONTENT = 3'd3;
   localparam logic [2:0] PH_ERROR   = 3'd4;

   localparam logic [ROLE_W-1:0] ROLE_LEN     = 3'd0;
   localparam logic [ROLE_W-1:0] ROLE_COUNT   = 3'd1;
   localparam logic [ROLE_W-1:0] ROLE_ARGLEN  = 3'd2;
   localparam logic [ROLE_W-1:0] ROLE_CONTENT = 3'd3;
   localparam logic [ROLE_W-1:0] ROLE_REJECT  = 3'd4;

   localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DEL   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNREC = 2'd3;

   // Outcome of one byte.
   localparam logic [1:0] ST_GO    = 2'd0;
   localparam logic [1:0] ST_CLEAN = 2'd1;
   localparam logic [1:0] ST_ERR   = 2'd2;

   // Bit positions in the first-argument match vector.
   localparam int M_GET  = 0;
   localparam int M_SET  = 1;
   localparam int M_DEL  = 2;
   localparam int M_LEN3 = 3;

   localparam logic [23:0] WORD_GET = 24'h676574;
   localparam logic [23:0] WORD_SET = 24'h736574;
   localparam logic [23:0] WORD_DEL = 24'h64656C;

   // Character of a three-letter command word at position pos (0 is first).
   function automatic logic [BYTE_W-1:0] word_char(input logic [23:0] word,
                                                   input logic [1:0] pos);
      logic [BYTE_W-1:0] c;
      case (pos)
         2'd0: c = word[23:16];
         2'd1: c = word[15:8];
         2'd2: c = word[7:0];
         default: c = word[23:16];
      endcase
      return c;
   endfunction

endpackage

// ----- sv/lprp_req_if.sv -----
// Request byte channel of the length-prefixed request parser.
// Depends on lprp_pkg for the byte width.

interface lprp_req_if;
   logic                          valid;
   logic                          ready;
   logic [lprp_pkg::BYTE_W-1:0]   byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

// ----- sv/lprp_rsp_if.sv -----
// Tagged result byte channel of the length-prefixed request parser.
// Depends on lprp_pkg for the field widths.

interface lprp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lprp_pkg::BYTE_W-1:0]      byte_out;
   logic [lprp_pkg::ROLE_W-1:0]      role;
   logic [lprp_pkg::ARG_IDX_W-1:0]   arg_index;
   logic                             arg_last;
   logic                             frame_done;
   logic                             frame_error;
   logic [lprp_pkg::CMD_W-1:0]       command;

   modport source (output valid, output byte_out, output role, output arg_index,
                   output arg_last, output frame_done, output frame_error,
                   output command, input ready);
   modport sink   (input valid, input byte_out, input role, input arg_index,
                   input arg_last, input frame_done, input frame_error,
                   input command, output ready);
endinterface

// ----- sv/lprp_csr_if.sv -----
// Register write channel of the length-prefixed request parser.
// Depends on lprp_pkg for the index and data widths.

interface lprp_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lprp_pkg::CSR_INDEX_W-1:0]  index;
   logic [lprp_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/length_prefixed_request_parser.sv -----
// Length-prefixed request parser: tags each request byte with its role in the frame.
// Depends on lprp_pkg and the interfaces lprp_req_if, lprp_rsp_if and lprp_csr_if.
//
//   Channel   Dir   Port      Carries
//   request   in    req_bus   byte_in, one byte per beat
//   result    out   rsp_bus   byte_out, role, arg_index, arg_last, frame_done,
//                             frame_error, command, one beat per request beat
//   config    in    csr_bus   index, data; always ready
//
// One byte per clock sustained while rsp_bus.ready is high; a result appears in the cycle after its byte is taken.
// The parse state and the result register update in the cycle the byte is accepted.
// req_bus.ready is high while the result register is empty or being drained.
// Synchronous reset restores the register defaults and the start-of-frame state.
// An error is sticky: every later byte is rejected until reset.

module length_prefixed_request_parser (
   input  logic         clock,
   input  logic         reset,
   lprp_req_if.sink     req_bus,
   lprp_rsp_if.source   rsp_bus,
   lprp_csr_if.sink     csr_bus
);

   logic [lprp_pkg::WORD_W-1:0]    max_frame_len_ff;
   logic [lprp_pkg::ARG_IDX_W-1:0] max_args_ff;

   logic [2:0]                     phase_ff, phase_in;
   logic [1:0]                     fbc_ff, fbc_in;
   logic [lprp_pkg::WORD_W-1:0]    accum_ff, accum_in;
   logic [lprp_pkg::WORD_W-1:0]    fbl_ff, fbl_in;
   logic [lprp_pkg::ARG_IDX_W-1:0] decl_ff, decl_in;
   logic [lprp_pkg::ARG_IDX_W-1:0] cur_ff, cur_in;
   logic [lprp_pkg::WORD_W-1:0]    abl_ff, abl_in;
   logic [3:0]                     match_ff, match_in;

   logic                           rsp_valid_ff;
   logic [lprp_pkg::BYTE_W-1:0]    byte_ff;
   logic [lprp_pkg::ROLE_W-1:0]    role_ff, role_in;
   logic [lprp_pkg::ARG_IDX_W-1:0] idx_ff, idx_in;
   logic                           last_ff, last_in;
   logic                           done_ff, done_in;
   logic                           err_ff, err_in;
   logic [lprp_pkg::CMD_W-1:0]     cmd_ff, cmd_in;

   logic                           req_fire;
   logic [1:0]                     status;
   logic                           nf_check;
   logic                           field_full;
   logic [lprp_pkg::WORD_W-1:0]    accum_next;
   logic [lprp_pkg::WORD_W-1:0]    fbl_dec;
   logic [lprp_pkg::WORD_W-1:0]    abl_dec;
   logic [1:0]                     char_pos;
   logic [lprp_pkg::BYTE_W-1:0]    b;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign b             = req_bus.byte_in;

   function automatic logic [lprp_pkg::CMD_W-1:0] classify(
         input logic [lprp_pkg::ARG_IDX_W-1:0] decl, input logic [3:0] m);
      logic [lprp_pkg::CMD_W-1:0] c;
      c = lprp_pkg::CMD_UNREC;
      if (decl == 24'd2 && m[lprp_pkg::M_LEN3] && m[lprp_pkg::M_GET]) begin
         c = lprp_pkg::CMD_GET;
      end else if (decl == 24'd3 && m[lprp_pkg::M_LEN3] && m[lprp_pkg::M_SET]) begin
         c = lprp_pkg::CMD_SET;
      end else if (decl == 24'd2 && m[lprp_pkg::M_LEN3] && m[lprp_pkg::M_DEL]) begin
         c = lprp_pkg::CMD_DEL;
      end
      return c;
   endfunction

   always_comb begin
      phase_in = phase_ff;
      fbc_in   = fbc_ff;
      accum_in = accum_ff;
      fbl_in   = fbl_ff;
      decl_in  = decl_ff;
      cur_in   = cur_ff;
      abl_in   = abl_ff;
      match_in = match_ff;
      role_in  = lprp_pkg::ROLE_REJECT;
      idx_in   = '0;
      last_in  = 1'b0;
      done_in  = 1'b0;
      err_in   = 1'b0;
      cmd_in   = lprp_pkg::CMD_UNREC;
      status   = lprp_pkg::ST_GO;
      nf_check = 1'b0;

      accum_next = {accum_ff[23:0], b};
      fbl_dec    = fbl_ff - 32'd1;
      abl_dec    = abl_ff - 32'd1;
      field_full = (fbc_ff == 2'd3);
      // Remaining count 3, 2, 1 maps to word position 0, 1, 2.
      char_pos   = 2'd3 - abl_ff[1:0];

      case (phase_ff)
         lprp_pkg::PH_LEN: begin
            role_in  = lprp_pkg::ROLE_LEN;
            fbc_in   = fbc_ff + 2'd1;
            accum_in = field_full ? '0 : accum_next;
            if (field_full) begin
               if (accum_next > max_frame_len_ff || accum_next < 32'd4) begin
                  status = lprp_pkg::ST_ERR;
               end else begin
                  fbl_in   = accum_next;
                  phase_in = lprp_pkg::PH_COUNT;
               end
            end
         end
         lprp_pkg::PH_COUNT: begin
            role_in  = lprp_pkg::ROLE_COUNT;
            fbl_in   = fbl_dec;
            fbc_in   = fbc_ff + 2'd1;
            accum_in = field_full ? '0 : accum_next;
            if (field_full) begin
               if (accum_next > {8'd0, max_args_ff}) begin
                  status = lprp_pkg::ST_ERR;
               end else begin
                  decl_in  = accum_next[lprp_pkg::ARG_IDX_W-1:0];
                  cur_in   = '0;
                  nf_check = 1'b1;
               end
            end
         end
         lprp_pkg::PH_ARGLEN: begin
            role_in  = lprp_pkg::ROLE_ARGLEN;
            idx_in   = cur_ff;
            fbl_in   = fbl_dec;
            fbc_in   = fbc_ff + 2'd1;
            accum_in = field_full ? '0 : accum_next;
            if (field_full) begin
               if (accum_next > fbl_dec) begin
                  status = lprp_pkg::ST_ERR;
               end else begin
                  if (cur_ff == '0) begin
                     match_in = (accum_next == 32'd3) ? 4'b1111 : 4'b0000;
                  end
                  abl_in = accum_next;
                  if (accum_next == '0) begin
                     last_in  = 1'b1;
                     cur_in   = cur_ff + 24'd1;
                     nf_check = 1'b1;
                  end else begin
                     phase_in = lprp_pkg::PH_CONTENT;
                  end
               end
            end
         end
         lprp_pkg::PH_CONTENT: begin
            role_in = lprp_pkg::ROLE_CONTENT;
            idx_in  = cur_ff;
            // The first argument is compared against the command words on the fly.
            if (cur_ff == '0 && match_ff[lprp_pkg::M_LEN3] && abl_ff <= 32'd3) begin
               if (b != lprp_pkg::word_char(lprp_pkg::WORD_GET, char_pos)) begin
                  match_in[lprp_pkg::M_GET] = 1'b0;
               end
               if (b != lprp_pkg::word_char(lprp_pkg::WORD_SET, char_pos)) begin
                  match_in[lprp_pkg::M_SET] = 1'b0;
               end
               if (b != lprp_pkg::word_char(lprp_pkg::WORD_DEL, char_pos)) begin
                  match_in[lprp_pkg::M_DEL] = 1'b0;
               end
            end
            fbl_in = fbl_dec;
            abl_in = abl_dec;
            if (abl_dec == '0) begin
               last_in  = 1'b1;
               cur_in   = cur_ff + 24'd1;
               nf_check = 1'b1;
            end
         end
         default: begin
            err_in = 1'b1;
         end
      endcase

      // Once the argument count is read or an argument is complete, decide whether the frame ends or continues.
      if (nf_check) begin
         if (cur_in >= decl_in) begin
            status = (fbl_in == '0) ? lprp_pkg::ST_CLEAN : lprp_pkg::ST_ERR;
         end else if (fbl_in < 32'd4) begin
            status = lprp_pkg::ST_ERR;
         end else begin
            phase_in = lprp_pkg::PH_ARGLEN;
         end
      end

      if (status == lprp_pkg::ST_ERR) begin
         done_in  = 1'b1;
         err_in   = 1'b1;
         phase_in = lprp_pkg::PH_ERROR;
      end else if (status == lprp_pkg::ST_CLEAN) begin
         done_in  = 1'b1;
         cmd_in   = classify(decl_in, match_in);
         phase_in = lprp_pkg::PH_LEN;
         fbc_in   = '0;
         accum_in = '0;
         fbl_in   = '0;
         decl_in  = '0;
         cur_in   = '0;
         abl_in   = '0;
         match_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_frame_len_ff <= lprp_pkg::MAX_FRAME_LEN_RESET;
         max_args_ff      <= lprp_pkg::MAX_ARGS_RESET;
      end else if (csr_bus.valid) begin
         if (csr_bus.index == lprp_pkg::REG_MAX_FRAME_LEN) begin
            max_frame_len_ff <= csr_bus.data;
         end else if (csr_bus.index == lprp_pkg::REG_MAX_ARGS) begin
            max_args_ff <= csr_bus.data[lprp_pkg::ARG_IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lprp_pkg::PH_LEN;
         fbc_ff   <= '0;
         accum_ff <= '0;
         fbl_ff   <= '0;
         decl_ff  <= '0;
         cur_ff   <= '0;
         abl_ff   <= '0;
         match_ff <= '0;
      end else if (req_fire) begin
         phase_ff <= phase_in;
         fbc_ff   <= fbc_in;
         accum_ff <= accum_in;
         fbl_ff   <= fbl_in;
         decl_ff  <= decl_in;
         cur_ff   <= cur_in;
         abl_ff   <= abl_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= b;
         role_ff <= role_in;
         idx_ff  <= idx_in;
         last_ff <= last_in;
         done_ff <= done_in;
         err_ff  <= err_in;
         cmd_ff  <= cmd_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.byte_out    = byte_ff;
   assign rsp_bus.role        = role_ff;
   assign rsp_bus.arg_index   = idx_ff;
   assign rsp_bus.arg_last    = last_ff;
   assign rsp_bus.frame_done  = done_ff;
   assign rsp_bus.frame_error = err_ff;
   assign rsp_bus.command     = cmd_ff;

`ifndef NO_ASSERTIONS
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == lprp_pkg::PH_ERROR |=> phase_ff == lprp_pkg::PH_ERROR)
      else $error("parser left the error phase without reset");

   a_clean_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && status == lprp_pkg::ST_CLEAN)
      |=> (phase_ff == lprp_pkg::PH_LEN && fbc_ff == 2'd0 && fbl_ff == '0))
      else $error("clean frame end did not return to the frame length field");

   a_reject_tagging: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && role_ff == lprp_pkg::ROLE_REJECT)
      |-> (err_ff && !done_ff && cmd_ff == lprp_pkg::CMD_UNREC && idx_ff == '0))
      else $error("rejected beat carries inconsistent tags");

   a_command_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cmd_ff != lprp_pkg::CMD_UNREC) |-> (done_ff && !err_ff))
      else $error("command reported on a beat that is not a clean frame end");

   a_arg_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == lprp_pkg::PH_ARGLEN || phase_ff == lprp_pkg::PH_CONTENT)
      |-> cur_ff < decl_ff)
      else $error("argument index ran past the declared count");
`endif

endmodule

// ----- bench/length_prefixed_request_parser_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for length_prefixed_request_parser: drives request bytes and
// register writes, predicts every tagged result beat and compares it field by field.
// Depends on lprp_pkg and the interfaces lprp_req_if, lprp_rsp_if and lprp_csr_if.

module length_prefixed_request_parser_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [lprp_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic [lprp_pkg::BYTE_W-1:0]    byte_out;
      logic [lprp_pkg::ROLE_W-1:0]    role;
      logic [lprp_pkg::ARG_IDX_W-1:0] arg_index;
      logic                           arg_last;
      logic                           frame_done;
      logic                           frame_error;
      logic [lprp_pkg::CMD_W-1:0]     command;
   } parsed_byte_type;

   typedef struct {
      logic [lprp_pkg::BYTE_W-1:0] value;
      bit                          spelled;
      parsed_byte_type             want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   lprp_req_if req_bus ();
   lprp_rsp_if rsp_bus ();
   lprp_csr_if csr_bus ();

   length_prefixed_request_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser state as the block should hold it, starting from its reset values.
   logic [2:0]                     parse_phase   = lprp_pkg::PH_LEN;
   logic [1:0]                     field_bytes   = '0;
   logic [lprp_pkg::WORD_W-1:0]    field_value   = '0;
   logic [lprp_pkg::WORD_W-1:0]    body_left     = '0;
   logic [lprp_pkg::ARG_IDX_W-1:0] arg_count     = '0;
   logic [lprp_pkg::ARG_IDX_W-1:0] arg_at        = '0;
   logic [lprp_pkg::WORD_W-1:0]    arg_left      = '0;
   logic [3:0]                     word_hits     = '0;
   logic                           error_latched = 1'b0;
   logic [lprp_pkg::WORD_W-1:0]    limit_frame_len = lprp_pkg::MAX_FRAME_LEN_RESET;
   logic [lprp_pkg::ARG_IDX_W-1:0] limit_args      = lprp_pkg::MAX_ARGS_RESET;

   parsed_byte_type  expected_beats[$];
   stim_row_type     directed[$];
   logic [7:0]       frame_bytes[$];
   int               mismatches = 0;
   int               bytes_sent = 0;
   int unsigned      cycles = 0;
   bit               calm = 1'b0;

   // Decides what follows once arg_at arguments are complete.
   function automatic logic [1:0] after_argument();
      if (arg_at >= arg_count)
         return (body_left == 0) ? lprp_pkg::ST_CLEAN : lprp_pkg::ST_ERR;
      if (body_left < 4) return lprp_pkg::ST_ERR;
      parse_phase = lprp_pkg::PH_ARGLEN;
      return lprp_pkg::ST_GO;
   endfunction

   function automatic parsed_byte_type parse_byte(input logic [7:0] b);
      parsed_byte_type r;
      logic [1:0]      outcome;
      logic [31:0]     v;
      int              pos;
      r = '{b, lprp_pkg::ROLE_REJECT, 24'd0, 1'b0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC};
      outcome = lprp_pkg::ST_GO;
      if (error_latched || parse_phase > lprp_pkg::PH_CONTENT) begin
         r.frame_error = 1'b1;
      end else if (parse_phase != lprp_pkg::PH_CONTENT) begin
         r.role = parse_phase;
         if (parse_phase == lprp_pkg::PH_ARGLEN) r.arg_index = arg_at;
         if (parse_phase != lprp_pkg::PH_LEN) body_left = body_left - 1;
         field_value = {field_value[23:0], b};
         field_bytes = field_bytes + 2'd1;
         if (field_bytes == 2'd0) begin
            v = field_value;
            field_value = '0;
            if (parse_phase == lprp_pkg::PH_LEN) begin
               if (v > limit_frame_len || v < 4) begin
                  outcome = lprp_pkg::ST_ERR;
               end else begin
                  body_left = v;
                  parse_phase = lprp_pkg::PH_COUNT;
               end
            end else if (parse_phase == lprp_pkg::PH_COUNT) begin
               if (v > limit_args) begin
                  outcome = lprp_pkg::ST_ERR;
               end else begin
                  arg_count = v[lprp_pkg::ARG_IDX_W-1:0];
                  arg_at = '0;
                  outcome = after_argument();
               end
            end else if (v > body_left) begin
               outcome = lprp_pkg::ST_ERR;
            end else begin
               if (arg_at == 0) word_hits = (v == 3) ? 4'b1111 : 4'b0000;
               arg_left = v;
               if (v == 0) begin
                  r.arg_last = 1'b1;
                  arg_at = arg_at + 1'b1;
                  outcome = after_argument();
               end else begin
                  parse_phase = lprp_pkg::PH_CONTENT;
               end
            end
         end
      end else begin
         r.role = lprp_pkg::ROLE_CONTENT;
         r.arg_index = arg_at;
         // Only a three-byte first argument can name a command.
         if (arg_at == 0 && word_hits[lprp_pkg::M_LEN3] && arg_left <= 3) begin
            pos = 3 - int'(arg_left);
            if (b != 8'(lprp_pkg::WORD_GET >> (16 - 8 * pos)))
               word_hits[lprp_pkg::M_GET] = 1'b0;
            if (b != 8'(lprp_pkg::WORD_SET >> (16 - 8 * pos)))
               word_hits[lprp_pkg::M_SET] = 1'b0;
            if (b != 8'(lprp_pkg::WORD_DEL >> (16 - 8 * pos)))
               word_hits[lprp_pkg::M_DEL] = 1'b0;
         end
         body_left = body_left - 1;
         arg_left = arg_left - 1;
         if (arg_left == 0) begin
            r.arg_last = 1'b1;
            arg_at = arg_at + 1'b1;
            outcome = after_argument();
         end
      end

      if (outcome == lprp_pkg::ST_ERR) begin
         r.frame_done = 1'b1;
         r.frame_error = 1'b1;
         error_latched = 1'b1;
         parse_phase = lprp_pkg::PH_ERROR;
      end else if (outcome == lprp_pkg::ST_CLEAN) begin
         r.frame_done = 1'b1;
         if (arg_count == 2 && word_hits[lprp_pkg::M_LEN3] && word_hits[lprp_pkg::M_GET])
            r.command = lprp_pkg::CMD_GET;
         else if (arg_count == 3 && word_hits[lprp_pkg::M_LEN3] && word_hits[lprp_pkg::M_SET])
            r.command = lprp_pkg::CMD_SET;
         else if (arg_count == 2 && word_hits[lprp_pkg::M_LEN3] && word_hits[lprp_pkg::M_DEL])
            r.command = lprp_pkg::CMD_DEL;
         else
            r.command = lprp_pkg::CMD_UNREC;
         parse_phase = lprp_pkg::PH_LEN;
         field_bytes = '0;
         field_value = '0;
         body_left = '0;
         arg_count = '0;
         arg_at = '0;
         arg_left = '0;
         word_hits = '0;
      end
      return r;
   endfunction

   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 9);
   endfunction

   function automatic stim_row_type model_row(input logic [7:0] value);
      stim_row_type row;
      row.value = value;
      row.spelled = 1'b0;
      row.want = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] value,
                                              input logic [lprp_pkg::ROLE_W-1:0] role,
                                              input logic [lprp_pkg::ARG_IDX_W-1:0] idx,
                                              input logic last, input logic done,
                                              input logic [lprp_pkg::CMD_W-1:0] cmd);
      stim_row_type row;
      row.value = value;
      row.spelled = 1'b1;
      row.want = '{value, role, idx, last, done, 1'b0, cmd};
      return row;
   endfunction

   function automatic void append_frame_byte(input logic [7:0] value);
      frame_bytes.insert(frame_bytes.size(), value);
   endfunction

   function automatic void push_be32(input logic [31:0] v);
      append_frame_byte(v[31:24]);
      append_frame_byte(v[23:16]);
      append_frame_byte(v[15:8]);
      append_frame_byte(v[7:0]);
   endfunction

   function automatic void compare_field(input string field, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
      end
   endfunction

   // All tasks below start and end at a falling clock edge.
   task automatic send_byte(input logic [7:0] value, input bit spelled,
                            input parsed_byte_type want);
      parsed_byte_type predicted;
      while (take_break()) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.byte_in <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = parse_byte(value);
      expected_beats.insert(expected_beats.size(), spelled ? want : predicted);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame_bytes();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
      frame_bytes.delete();
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [lprp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [31:0] data);
      wait_drained();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (index == lprp_pkg::REG_MAX_FRAME_LEN) limit_frame_len = data;
      else if (index == lprp_pkg::REG_MAX_ARGS) limit_args = data[lprp_pkg::ARG_IDX_W-1:0];
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly well-formed frames: get, set and del, near misses of the command
   // words, wrong argument counts, random arguments and empty frames.
   task automatic send_random_frame(input int max_count, input int max_arg_len);
      int         kind;
      int         n;
      int         body;
      int         arg_len[8];
      bit         has_word;
      logic [7:0] word[3];
      logic [23:0] pick;
      kind = $urandom_range(9);
      case (kind)
         0, 1:    begin pick = lprp_pkg::WORD_GET; n = 2; end
         2, 3:    begin pick = lprp_pkg::WORD_SET; n = 3; end
         4, 5:    begin pick = lprp_pkg::WORD_DEL; n = 2; end
         default: begin
            case ($urandom_range(2))
               0:       pick = lprp_pkg::WORD_GET;
               1:       pick = lprp_pkg::WORD_SET;
               default: pick = lprp_pkg::WORD_DEL;
            endcase
            n = (kind == 9) ? 0 : (kind == 8) ? $urandom_range(8, 1) : $urandom_range(4, 1);
         end
      endcase
      word[0] = pick[23:16];
      word[1] = pick[15:8];
      word[2] = pick[7:0];
      if (kind == 6) word[$urandom_range(2)] ^= 8'(1 << $urandom_range(7));
      if (n > max_count) n = max_count;
      has_word = (kind <= 7) && (n > 0);
      body = 4;
      for (int i = 0; i < n; i++) begin
         if (i == 0 && has_word) arg_len[i] = 3;
         else if ($urandom_range(9) == 0) arg_len[i] = $urandom_range(max_arg_len);
         else arg_len[i] = $urandom_range((max_arg_len < 4) ? max_arg_len : 4);
         body += 4 + arg_len[i];
      end
      push_be32(body);
      push_be32(n);
      for (int i = 0; i < n; i++) begin
         push_be32(arg_len[i]);
         for (int j = 0; j < arg_len[i]; j++)
            append_frame_byte((i == 0 && has_word) ? word[j] : 8'($urandom_range(255)));
      end
      send_frame_bytes();
   endtask

   // One malformed frame of a random kind, then bytes that must all be rejected.
   task automatic send_broken_frame();
      int extra;
      extra = $urandom_range(20, 1);
      case ($urandom_range(4))
         0: begin
            case ($urandom_range(2))
               0: begin
                  write_reg(lprp_pkg::REG_MAX_FRAME_LEN, 32'd0);
                  push_be32($urandom_range(64, 4));
               end
               1:       push_be32($urandom_range(3));
               default: push_be32($urandom_range(32'hFFFF_FFFF, limit_frame_len + 1));
            endcase
         end
         1: begin
            push_be32(16);
            push_be32($urandom_range(32'hFFFF_FFFF, limit_args + 1));
         end
         2: begin
            // Too few body bytes left for the first argument length.
            push_be32(4 + $urandom_range(3, 1));
            push_be32(1);
         end
         3: begin
            push_be32(12);
            push_be32(1);
            push_be32($urandom_range(1000, 5));
         end
         default: begin
            push_be32(4 + 4 + 2 + extra);
            push_be32(1);
            push_be32(2);
            push_be32($urandom);
         end
      endcase
      repeat (40) append_frame_byte(8'($urandom_range(255)));
      send_frame_bytes();
   endtask

   always @(negedge clock) rsp_bus.ready <= !take_break();

   always @(posedge clock) begin
      parsed_byte_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_beats.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with byte 0x%0h arrived, none expected",
                     $time, rsp_bus.byte_out);
         end else begin
            want = expected_beats.pop_front();
            compare_field("byte_out", 32'(want.byte_out), 32'(rsp_bus.byte_out));
            compare_field("role", 32'(want.role), 32'(rsp_bus.role));
            compare_field("arg_index", 32'(want.arg_index), 32'(rsp_bus.arg_index));
            compare_field("arg_last", 32'(want.arg_last), 32'(rsp_bus.arg_last));
            compare_field("frame_done", 32'(want.frame_done), 32'(rsp_bus.frame_done));
            compare_field("frame_error", 32'(want.frame_error), 32'(rsp_bus.frame_error));
            compare_field("command", 32'(want.command), 32'(rsp_bus.command));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.byte_in = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;

      // An empty frame, then a get whose key is the single byte 0xFF.
      directed = '{
         typed_row(8'h00, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h04, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_COUNT, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_COUNT, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_COUNT, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_COUNT, 24'd0, 1'b0, 1'b1, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h00, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         typed_row(8'h10, lprp_pkg::ROLE_LEN, 24'd0, 1'b0, 1'b0, lprp_pkg::CMD_UNREC),
         model_row(8'h00), model_row(8'h00), model_row(8'h00), model_row(8'h02),
         model_row(8'h00), model_row(8'h00), model_row(8'h00), model_row(8'h03),
         model_row(8'h67), model_row(8'h65), model_row(8'h74),
         model_row(8'h00), model_row(8'h00), model_row(8'h00), model_row(8'h01),
         typed_row(8'hFF, lprp_pkg::ROLE_CONTENT, 24'd1, 1'b1, 1'b1, lprp_pkg::CMD_GET)
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_byte(directed[i].value, directed[i].spelled, directed[i].want);
      while (bytes_sent < 450) send_random_frame(8, 16);

      write_reg(lprp_pkg::REG_MAX_FRAME_LEN, 32'hFFFF_FFFF);
      write_reg(lprp_pkg::REG_MAX_ARGS, 32'h00FF_FFFF);
      write_reg(REG_UNMAPPED, $urandom);
      calm = 1'b1;
      while (bytes_sent < 700) send_random_frame(8, 16);
      calm = 1'b0;
      while (bytes_sent < 950) send_random_frame(8, 16);

      // Smallest usable limits: only empty frames of exactly four body bytes pass.
      write_reg(lprp_pkg::REG_MAX_FRAME_LEN, 32'd4);
      write_reg(lprp_pkg::REG_MAX_ARGS, 32'd0);
      repeat (12) send_random_frame(0, 0);

      write_reg(lprp_pkg::REG_MAX_FRAME_LEN, 32'd64);
      write_reg(lprp_pkg::REG_MAX_ARGS, 32'd3);
      while (bytes_sent < 1450) send_random_frame(3, 12);

      // The error is sticky until reset, so the malformed frame comes last.
      send_broken_frame();

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
